// File: design/packet_ring_fifo_defines.svh
// Assertion macros shared by the packet ring FIFO RTL.
`ifndef PACKET_RING_FIFO_DEFINES_SVH
`define PACKET_RING_FIFO_DEFINES_SVH

`ifndef ASSERT_OFF

// Condition must hold at every clock edge outside reset.
`define PRF_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define PRF_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PRF_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PRF_ASSERT_ALWAYS(name, cond, msg)
`define PRF_ASSERT_IMPL(name, ante, cons, msg)
`define PRF_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// File: design/prf_pkg.sv
// Shared constants, codes and controller/datapath types for the packet ring FIFO.
package prf_pkg;

    localparam int SLOTS       = 16;
    localparam int SLOT_BYTES  = 2048;
    localparam int RECORD_BITS = 64;

    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int OFF_W       = $clog2(SLOT_BYTES);
    localparam int LEN_W       = $clog2(SLOT_BYTES + 1);
    localparam int BYTE_ADDR_W = SLOT_W + OFF_W;

    localparam int CAP_W       = 4;
    localparam int MAXLEN_W    = 12;
    localparam int CFG_W       = 12;
    localparam int CFG_IDX_W   = 1;
    localparam int STATUS_W    = 3;
    localparam int OFFSET_W    = 11;
    localparam int DEPTH_W     = 4;
    localparam int LENOUT_W    = 12;

    localparam logic [CAP_W-1:0]    CAP_RESET    = 4'd15;
    localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = 12'd2048;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_RING_CAPACITY    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PACKET_BYTES = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DROP_FULL  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DROP_LONG  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_OFFSET = 3'd4;

    typedef enum logic [1:0] {
        FUNC_PUSH   = 2'd0,
        FUNC_READ   = 2'd1,
        FUNC_POP    = 2'd2,
        FUNC_STATUS = 2'd3
    } t_func;

    typedef struct packed {
        logic load;     // capture the input transaction
        logic exec;     // update pointers, write memories, start reads
        logic rd_done;  // memory read data is valid
        logic wb;       // move pending result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic read_hit; // read of a non-empty ring, needs a RAM read
    } t_dp_sts;

endpackage

// File: design/prf_ram.sv
// Generic simple dual-port RAM with registered read.
module prf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/prf_ctrl.sv
// Transaction sequencer and output handshake for the packet ring FIFO.
module prf_ctrl
    import prf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_RDATA = 4'b0100,
        S_WBACK = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.read_hit ? S_RDATA : S_WBACK;
            end
            S_RDATA: begin
                o_cmd.rd_done = 1'b1;
                n_state       = S_WBACK;
            end
            S_WBACK: begin
                if (out_free) begin
                    o_cmd.wb = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.wb) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: design/prf_dp.sv
// Datapath: ring pointers, configuration, packet memories and result registers.
module prf_dp
    import prf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  logic [1:0]             i_func,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_byte_valid,
    input  logic                   i_last_item,
    input  logic [RECORD_BITS-1:0] i_record_in,
    input  logic [OFFSET_W-1:0]    i_read_offset,
    output logic [STATUS_W-1:0]    o_status,
    output logic [7:0]             o_read_byte,
    output logic [RECORD_BITS-1:0] o_record_out,
    output logic [LENOUT_W-1:0]    o_length_out,
    output logic [DEPTH_W-1:0]     o_depth_out,
    output logic                   o_empty_flag,
    output logic                   o_full_flag
);

    // configuration and ring state
    logic [CAP_W-1:0]    r_cap, n_cap;
    logic [MAXLEN_W-1:0] r_max_len, n_max_len;
    logic [SLOT_W-1:0]   r_wr_slot, n_wr_slot;
    logic [SLOT_W-1:0]   r_rd_slot, n_rd_slot;
    logic [LEN_W-1:0]    r_byte_cnt, n_byte_cnt;
    logic                r_too_long, n_too_long;

    // captured transaction
    t_func                r_func;
    logic [7:0]           r_data;
    logic                 r_bvalid;
    logic                 r_last;
    logic [RECORD_BITS-1:0] r_rec;
    logic [OFFSET_W-1:0]  r_off;

    // pending result
    logic [STATUS_W-1:0]    r_p_status;
    logic [7:0]             r_p_byte;
    logic [RECORD_BITS-1:0] r_p_rec;
    logic [LENOUT_W-1:0]    r_p_len;

    // output register
    logic [STATUS_W-1:0]    r_o_status;
    logic [7:0]             r_o_byte;
    logic [RECORD_BITS-1:0] r_o_rec;
    logic [LENOUT_W-1:0]    r_o_len;
    logic [DEPTH_W-1:0]     r_o_depth;
    logic                   r_o_empty;
    logic                   r_o_full;

    logic [SLOT_W:0]    slots_used;
    logic [SLOT_W:0]    wr_inc, rd_inc;
    logic [SLOT_W-1:0]  wr_next, rd_next;
    logic               ring_empty, ring_full;
    logic [SLOT_W:0]    depth;
    logic [LEN_W-1:0]   eff_max;
    logic               room;
    logic               tl_now;
    logic               is_push, byte_store, commit;
    logic [LEN_W-1:0]   cnt_after;
    logic [7:0]         byte_rdata;
    logic [RECORD_BITS-1:0] rec_rdata;
    logic [LEN_W-1:0]   len_rdata;
    logic               off_ok;

    always_comb begin
        if ({1'b0, r_cap} >= SLOTS) begin
            slots_used = (SLOT_W+1)'(SLOTS);
        end else begin
            slots_used = (SLOT_W+1)'(r_cap) + 1'b1;
        end
    end

    assign wr_inc  = {1'b0, r_wr_slot} + 1'b1;
    assign rd_inc  = {1'b0, r_rd_slot} + 1'b1;
    assign wr_next = (wr_inc >= slots_used) ? '0 : wr_inc[SLOT_W-1:0];
    assign rd_next = (rd_inc >= slots_used) ? '0 : rd_inc[SLOT_W-1:0];

    assign ring_empty = (r_rd_slot == r_wr_slot);
    assign ring_full  = (wr_next == r_rd_slot);

    assign depth = (r_wr_slot >= r_rd_slot)
                 ? ({1'b0, r_wr_slot} - {1'b0, r_rd_slot})
                 : (slots_used - {1'b0, r_rd_slot} + {1'b0, r_wr_slot});

    assign eff_max = (r_max_len > MAXLEN_W'(SLOT_BYTES)) ? LEN_W'(SLOT_BYTES)
                                                         : LEN_W'(r_max_len);
    assign room       = (r_byte_cnt < eff_max);
    assign is_push    = i_cmd.exec && (r_func == FUNC_PUSH);
    assign byte_store = is_push && r_bvalid && room;
    assign tl_now     = r_too_long || (r_bvalid && !room);
    assign commit     = is_push && r_last && !tl_now && !ring_full;
    assign cnt_after  = r_byte_cnt + LEN_W'(r_bvalid && room);

    assign o_sts.read_hit = (r_func == FUNC_READ) && !ring_empty;

    prf_ram #(.WIDTH(8), .DEPTH(SLOTS * SLOT_BYTES)) u_bytes (
        .i_clk   (i_clk),
        .i_we    (byte_store),
        .i_waddr ({r_wr_slot, r_byte_cnt[OFF_W-1:0]}),
        .i_wdata (r_data),
        .i_raddr ({r_rd_slot, r_off[OFF_W-1:0]}),
        .o_rdata (byte_rdata)
    );

    prf_ram #(.WIDTH(RECORD_BITS), .DEPTH(SLOTS)) u_records (
        .i_clk   (i_clk),
        .i_we    (commit),
        .i_waddr (r_wr_slot),
        .i_wdata (r_rec),
        .i_raddr (r_rd_slot),
        .o_rdata (rec_rdata)
    );

    prf_ram #(.WIDTH(LEN_W), .DEPTH(SLOTS)) u_lengths (
        .i_clk   (i_clk),
        .i_we    (commit),
        .i_waddr (r_wr_slot),
        .i_wdata (cnt_after),
        .i_raddr (r_rd_slot),
        .o_rdata (len_rdata)
    );

    assign off_ok = ({1'b0, r_off} < len_rdata);

    // pointer, counter and config next state
    always_comb begin
        n_cap      = r_cap;
        n_max_len  = r_max_len;
        n_wr_slot  = r_wr_slot;
        n_rd_slot  = r_rd_slot;
        n_byte_cnt = r_byte_cnt;
        n_too_long = r_too_long;
        if (i_cfg_we) begin
            if (i_cfg_index == REG_RING_CAPACITY) begin
                n_cap      = i_cfg_data[CAP_W-1:0];
                n_wr_slot  = '0;
                n_rd_slot  = '0;
                n_byte_cnt = '0;
                n_too_long = 1'b0;
            end else begin
                n_max_len = i_cfg_data[MAXLEN_W-1:0];
            end
        end else if (i_cmd.exec) begin
            unique case (r_func)
                FUNC_PUSH: begin
                    if (r_last) begin
                        n_byte_cnt = '0;
                        n_too_long = 1'b0;
                        if (commit) begin
                            n_wr_slot = wr_next;
                        end
                    end else begin
                        n_byte_cnt = cnt_after;
                        n_too_long = tl_now;
                    end
                end
                FUNC_POP: begin
                    if (!ring_empty) begin
                        n_rd_slot = rd_next;
                    end
                end
                FUNC_READ, FUNC_STATUS: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap      <= CAP_RESET;
            r_max_len  <= MAXLEN_RESET;
            r_wr_slot  <= '0;
            r_rd_slot  <= '0;
            r_byte_cnt <= '0;
            r_too_long <= 1'b0;
        end else begin
            r_cap      <= n_cap;
            r_max_len  <= n_max_len;
            r_wr_slot  <= n_wr_slot;
            r_rd_slot  <= n_rd_slot;
            r_byte_cnt <= n_byte_cnt;
            r_too_long <= n_too_long;
        end
    end

    // transaction capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func   <= t_func'(i_func);
            r_data   <= i_data_byte;
            r_bvalid <= i_byte_valid;
            r_last   <= i_last_item;
            r_rec    <= i_record_in;
            r_off    <= i_read_offset;
        end
    end

    // pending result
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_p_byte <= '0;
            r_p_rec  <= '0;
            r_p_len  <= '0;
            unique case (r_func)
                FUNC_PUSH: begin
                    if (!r_last) begin
                        r_p_status <= ST_OK;
                    end else if (tl_now) begin
                        r_p_status <= ST_DROP_LONG;
                    end else if (ring_full) begin
                        r_p_status <= ST_DROP_FULL;
                    end else begin
                        r_p_status <= ST_OK;
                    end
                end
                FUNC_READ, FUNC_POP: begin
                    r_p_status <= ring_empty ? ST_EMPTY : ST_OK;
                end
                FUNC_STATUS: r_p_status <= ST_OK;
                default:     r_p_status <= ST_OK;
            endcase
        end else if (i_cmd.rd_done) begin
            r_p_status <= off_ok ? ST_OK : ST_BAD_OFFSET;
            r_p_byte   <= off_ok ? byte_rdata : 8'd0;
            r_p_rec    <= rec_rdata;
            r_p_len    <= LENOUT_W'(len_rdata);
        end
    end

    // output register; ring status reflects pointers after this transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.wb) begin
            r_o_status <= r_p_status;
            r_o_byte   <= r_p_byte;
            r_o_rec    <= r_p_rec;
            r_o_len    <= r_p_len;
            r_o_depth  <= depth[DEPTH_W-1:0];
            r_o_empty  <= ring_empty;
            r_o_full   <= ring_full;
        end
    end

    assign o_status     = r_o_status;
    assign o_read_byte  = r_o_byte;
    assign o_record_out = r_o_rec;
    assign o_length_out = r_o_len;
    assign o_depth_out  = r_o_depth;
    assign o_empty_flag = r_o_empty;
    assign o_full_flag  = r_o_full;

endmodule

// File: design/packet_ring_fifo.sv
// Top level of the packet ring FIFO: sequencer, datapath and checks.
// Flow: capture in IDLE, execute in EXEC, a RAM read in RDATA for a read of a stored
//   packet only, then write-back in WBACK into the output register; output stalls hold
//   WBACK. A new transaction is accepted only after the write-back, so one is in flight
//   at a time.
// Reset: synchronous, active low; clears pointers and handshakes, loads 15/2048; RAMs kept.
`include "packet_ring_fifo_defines.svh"

module packet_ring_fifo
    import prf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration writes, only while idle
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data,
    // input transactions
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [1:0]             i_func,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_byte_valid,
    input  logic                   i_last_item,
    input  logic [RECORD_BITS-1:0] i_record_in,
    input  logic [OFFSET_W-1:0]    i_read_offset,
    // result transactions
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [STATUS_W-1:0]    o_status,
    output logic [7:0]             o_read_byte,
    output logic [RECORD_BITS-1:0] o_record_out,
    output logic [LENOUT_W-1:0]    o_length_out,
    output logic [DEPTH_W-1:0]     o_depth_out,
    output logic                   o_empty_flag,
    output logic                   o_full_flag
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // Sequencer: IDLE takes a transaction, EXEC applies it to the ring, RDATA picks
    // up the RAM read for a head read, WBACK waits for the output register to free.
    prf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    // Datapath: one slot is always kept spare for the packet being pushed, so
    // bytes land in the write slot and commit advances the write pointer and stores the record and length.
    // Too-long wins over full; both drop the whole packet at its last byte.
    prf_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_func        (i_func),
        .i_data_byte   (i_data_byte),
        .i_byte_valid  (i_byte_valid),
        .i_last_item   (i_last_item),
        .i_record_in   (i_record_in),
        .i_read_offset (i_read_offset),
        .o_status      (o_status),
        .o_read_byte   (o_read_byte),
        .o_record_out  (o_record_out),
        .o_length_out  (o_length_out),
        .o_depth_out   (o_depth_out),
        .o_empty_flag  (o_empty_flag),
        .o_full_flag   (o_full_flag)
    );

    // one transaction in flight at a time
    `PRF_ASSERT_NEXT(a_one_in_flight, i_in_valid && o_in_ready, !o_in_ready, "double accept")

    // empty flag and depth agree on every result
    `PRF_ASSERT_IMPL(a_empty, o_out_valid, o_empty_flag == (o_depth_out == '0), "empty/depth")

    // a byte is only returned on a good read
    `PRF_ASSERT_IMPL(a_byte_ok, o_out_valid && o_status != ST_OK, o_read_byte == '0, "bad byte")

    // exec and rd_done never happen together with a write-back
    `PRF_ASSERT_ALWAYS(a_cmd_excl, !(dp_cmd.wb && (dp_cmd.exec || dp_cmd.rd_done)), "cmd overlap")

endmodule
